>>> hw/rtl/queue_sram_block_allocator_unit_macros.svh
// assertion helpers for the queue buffer allocator
`ifndef QUEUE_SRAM_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define QUEUE_SRAM_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// checked only while out of reset
`define QSBA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define QSBA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/qsba_pkg.sv
`default_nettype none

package qsba_pkg;

  localparam int STORE_UNITS    = 128;
  localparam int QUEUE_COUNT    = 64;
  localparam int RESERVED_UNITS = 4;

  localparam int UNIT_W   = $clog2(STORE_UNITS);
  localparam int QIDX_W   = $clog2(QUEUE_COUNT);
  localparam int QID_W    = 6;
  localparam int LEN_W    = 8;
  localparam int MARK_W   = 3;
  localparam int STATUS_W = 3;
  localparam int WORD_W   = 32;
  localparam int ADDR_F_W = 8;
  localparam int RUN_W    = 4;

  // packed queue word layout
  localparam int ADDR_LSB = 14;
  localparam int CODE_LSB = 24;
  localparam int EM_LSB   = 26;
  localparam int FM_LSB   = 29;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_BUSY      = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CMD_REQUEST = 1'b0,
    CMD_RELEASE = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } size_t;

  function automatic logic [STORE_UNITS-1:0] map_reset_val();
    logic [STORE_UNITS-1:0] m;
    m = '0;
    for (int j = 0; j < STORE_UNITS; j++) begin
      m[j] = (j < RESERVED_UNITS);
    end
    return m;
  endfunction

  localparam logic [STORE_UNITS-1:0] MapResetVal = map_reset_val();

  function automatic size_t size_decode(logic [LEN_W-1:0] len);
    size_t s;
    s.ok   = 1'b1;
    s.code = 2'd0;
    case (len)
      8'd16:   s.code = 2'd0;
      8'd32:   s.code = 2'd1;
      8'd64:   s.code = 2'd2;
      8'd128:  s.code = 2'd3;
      default: s.ok   = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic [RUN_W-1:0] code_units(logic [1:0] code);
    return RUN_W'(1) << code;
  endfunction

  // units base .. base+units-1 that lie inside the store
  function automatic logic [STORE_UNITS-1:0] window_mask(logic [ADDR_F_W-1:0] base,
                                                         logic [RUN_W-1:0] units);
    logic [STORE_UNITS-1:0] m;
    for (int j = 0; j < STORE_UNITS; j++) begin
      m[j] = (j >= int'(base)) && (j < int'(base) + int'(units));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/qsba_ram.sv
`default_nettype none

module qsba_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/queue_sram_block_allocator_unit.sv
// Queue buffer allocator for a 128-unit store of sixteen-word units.
// Input channel (in_valid_i / in_ready_o) carries one command word: request
// or release, queue number, length in words and two watermark codes. Every
// command returns one status word on the output channel (out_valid_o /
// out_ready_i). The queue table sits in a 64-entry synchronous RAM, the unit
// bitmap in a 128-bit register.
// Steps: S_LOOK reads the queue entry and settles a release or a rejected
// request; an accepted request then walks the bitmap first fit in S_SCAN,
// one unit per cycle, over up to all 128 units; S_FINISH registers the
// status. in_ready_o rises in the same cycle that the status is registered,
// so the first-fit walk sets how soon the next command can follow.
// Only one command is in flight; in_ready_o is high whenever no command is
// being worked on, even while a status waits in the output register.
// A stalled receiver holds the status; a finished command then waits until
// the output register is free.
// Reset clears the queue table (through per-entry valid bits) and marks the
// low four units used; no clearing pass is needed.
`default_nettype none
`include "queue_sram_block_allocator_unit_macros.svh"

module queue_sram_block_allocator_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         command_i,
  input  wire logic [qsba_pkg::QID_W-1:0]   queue_id_i,
  input  wire logic [qsba_pkg::LEN_W-1:0]   length_words_i,
  input  wire logic [qsba_pkg::MARK_W-1:0]  empty_mark_i,
  input  wire logic [qsba_pkg::MARK_W-1:0]  full_mark_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [qsba_pkg::STATUS_W-1:0]     status_o
);
  import qsba_pkg::*;

  state_e state_q, state_d;

  // captured command word
  logic                cmd_q;
  logic [QID_W-1:0]    qid_q;
  logic [LEN_W-1:0]    len_q;
  logic [MARK_W-1:0]   em_q;
  logic [MARK_W-1:0]   fm_q;

  logic [STORE_UNITS-1:0] map_q, map_d;
  logic [QUEUE_COUNT-1:0] tvalid_q, tvalid_d;
  logic [UNIT_W-1:0]      cnt_q, cnt_d;
  logic [RUN_W-1:0]       run_q, run_d;
  logic [1:0]             code_q, code_d;
  status_e                res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;

  logic              accept;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] entry;
  logic [QIDX_W-1:0] qidx;
  logic              q_bad;
  size_t             size;
  logic [RUN_W-1:0]  units;
  logic              unit_free;
  logic              found;
  logic [UNIT_W-1:0] win_addr;
  logic              scan_end;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign qidx       = qid_q[QIDX_W-1:0];
  assign q_bad      = (int'(qid_q) >= QUEUE_COUNT);
  assign entry      = tvalid_q[qidx] ? ram_rdata : '0;
  assign size       = size_decode(len_q);
  assign units      = code_units(code_q);
  assign unit_free  = !map_q[cnt_q];
  assign found      = unit_free && (run_q + RUN_W'(1) == units);
  assign win_addr   = cnt_q - UNIT_W'(units - RUN_W'(1));
  assign scan_end   = (cnt_q == UNIT_W'(STORE_UNITS - 1));

  qsba_ram #(
    .Width (WORD_W),
    .Depth (QUEUE_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (qidx),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (queue_id_i[QIDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_LOOK;
      end
      S_LOOK: begin
        if (!q_bad && cmd_q == CMD_REQUEST && size.ok && entry == '0) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        if (found || scan_end) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    map_d        = map_q;
    tvalid_d     = tvalid_q;
    cnt_d        = cnt_q;
    run_d        = run_q;
    code_d       = code_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_wdata    = '0;
    case (state_q)
      S_LOOK: begin
        cnt_d  = '0;
        run_d  = '0;
        code_d = size.code;
        if (q_bad) begin
          res_d = ST_INVALID;
        end else if (cmd_q == CMD_REQUEST) begin
          if (!size.ok) begin
            res_d = ST_INVALID;
          end else if (entry != '0) begin
            res_d = ST_BUSY;
          end
        end else if (entry == '0) begin
          res_d = ST_NOT_ALLOC;
        end else begin
          // free the recorded window and clear the entry
          map_d = map_q & ~window_mask(entry[ADDR_LSB +: ADDR_F_W],
                                       code_units(entry[CODE_LSB +: 2]));
          ram_we          = 1'b1;
          tvalid_d[qidx]  = 1'b1;
          res_d           = ST_OK;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + UNIT_W'(1);
        run_d = unit_free ? run_q + RUN_W'(1) : '0;
        if (found) begin
          map_d = map_q | window_mask(ADDR_F_W'(win_addr), units);
          ram_we = 1'b1;
          ram_wdata = (WORD_W'(win_addr) << ADDR_LSB) | (WORD_W'(code_q) << CODE_LSB) |
                      (WORD_W'(em_q) << EM_LSB) | (WORD_W'(fm_q) << FM_LSB);
          tvalid_d[qidx] = 1'b1;
          res_d = ST_OK;
        end else if (scan_end) begin
          res_d = ST_NO_SPACE;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      map_q       <= MapResetVal;
      tvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      map_q       <= map_d;
      tvalid_q    <= tvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      qid_q <= queue_id_i;
      len_q <= length_words_i;
      em_q  <= empty_mark_i;
      fm_q  <= full_mark_i;
    end
    cnt_q        <= cnt_d;
    run_q        <= run_d;
    code_q       <= code_d;
    res_q        <= res_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

  `QSBA_ASSERT(a_reserved_kept, (map_q & MapResetVal) == MapResetVal, "reserved unit freed")
  `QSBA_ASSERT(a_run_bound, (state_q == S_SCAN) |-> (run_q < units), "free run overran window")
  `QSBA_ASSERT(a_ram_write_state, ram_we |-> (state_q == S_LOOK || state_q == S_SCAN),
               "table written outside command work")
  `QSBA_ASSERT_ALWAYS(a_out_from_finish, $rose(out_valid_q) |-> $past(state_q == S_FINISH),
                      "status shown without a finished command")

endmodule

`default_nettype wire

>>> tb/queue_sram_block_allocator_unit_test.sv
`timescale 1ns / 1ps

module queue_sram_block_allocator_unit_test;
  import qsba_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 140;
  localparam int MAP_UNITS      = 128;
  localparam int QUEUES         = 64;

  localparam logic [LEN_W-1:0] LEN_16  = 8'd16;
  localparam logic [LEN_W-1:0] LEN_32  = 8'd32;
  localparam logic [LEN_W-1:0] LEN_64  = 8'd64;
  localparam logic [LEN_W-1:0] LEN_128 = 8'd128;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                command_i;
  logic [QID_W-1:0]    queue_id_i;
  logic [LEN_W-1:0]    length_words_i;
  logic [MARK_W-1:0]   empty_mark_i;
  logic [MARK_W-1:0]   full_mark_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;

  // predictor state: one bit per store unit, one packed word per queue
  logic [MAP_UNITS-1:0] unit_busy_map;
  logic [WORD_W-1:0]    queue_word_model[QUEUES];
  status_e              status_expect_q[$];

  bit idle_on;
  int fail_count;
  int idle_cycles;

  queue_sram_block_allocator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .queue_id_i     (queue_id_i),
    .length_words_i (length_words_i),
    .empty_mark_i   (empty_mark_i),
    .full_mark_i    (full_mark_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic status_e predict_status(command_e cmd, logic [QID_W-1:0] qid,
                                             logic [LEN_W-1:0] len,
                                             logic [MARK_W-1:0] em,
                                             logic [MARK_W-1:0] fm);
    logic [WORD_W-1:0] word;
    logic [1:0]        code;
    int                units;
    int                base;
    bit                fits;
    if (int'(qid) >= QUEUES) return ST_INVALID;
    if (cmd == CMD_RELEASE) begin
      word = queue_word_model[qid];
      if (word == '0) return ST_NOT_ALLOC;
      base  = int'(word[ADDR_LSB +: 8]);
      units = 1 << word[CODE_LSB +: 2];
      for (int i = 0; i < units; i++) begin
        if (base + i < MAP_UNITS) unit_busy_map[base + i] = 1'b0;
      end
      queue_word_model[qid] = '0;
      return ST_OK;
    end
    case (len)
      LEN_16:  code = 2'd0;
      LEN_32:  code = 2'd1;
      LEN_64:  code = 2'd2;
      LEN_128: code = 2'd3;
      default: return ST_INVALID;
    endcase
    if (queue_word_model[qid] != '0) return ST_BUSY;
    units = 1 << code;
    // first fit, one unit per step from unit 0
    for (base = 0; base + units <= MAP_UNITS; base++) begin
      fits = 1'b1;
      for (int i = 0; i < units; i++) begin
        if (unit_busy_map[base + i]) fits = 1'b0;
      end
      if (fits) begin
        for (int i = 0; i < units; i++) unit_busy_map[base + i] = 1'b1;
        word = '0;
        word[ADDR_LSB +: 8]      = base[7:0];
        word[CODE_LSB +: 2]      = code;
        word[EM_LSB +: MARK_W]   = em;
        word[FM_LSB +: MARK_W]   = fm;
        queue_word_model[qid] = word;
        return ST_OK;
      end
    end
    return ST_NO_SPACE;
  endfunction

  task automatic send_word(command_e cmd, logic [QID_W-1:0] qid, logic [LEN_W-1:0] len,
                           logic [MARK_W-1:0] em, logic [MARK_W-1:0] fm);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    queue_id_i     <= qid;
    length_words_i <= len;
    empty_mark_i   <= em;
    full_mark_i    <= fm;
    do @(posedge clk_i); while (!in_ready_o);
    status_expect_q.push_back(predict_status(cmd, qid, len, em, fm));
  endtask

  // sender holds off until every status word is back
  task automatic wait_status_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (status_expect_q.size() != 0);
  endtask

  // mostly picks a queue in the wanted state so sequences stay well formed
  function automatic logic [QID_W-1:0] pick_queue(bit allocated);
    int start;
    int q;
    start = $urandom_range(0, QUEUES - 1);
    if ($urandom_range(0, 4) == 0) return QID_W'(start);
    for (int k = 0; k < QUEUES; k++) begin
      q = (start + k) % QUEUES;
      if ((queue_word_model[q] != '0) == allocated) return QID_W'(q);
    end
    return QID_W'(start);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 6))
      0, 1, 2: return LEN_16;
      3, 4:    return LEN_32;
      5:       return LEN_64;
      default: return LEN_128;
    endcase
  endfunction

  task automatic send_random_word(int noise_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < noise_pct) begin
      send_word(command_e'($urandom_range(0, 1)), QID_W'($urandom_range(0, QUEUES - 1)),
                LEN_W'($urandom_range(0, 255)), MARK_W'($urandom_range(0, 7)),
                MARK_W'($urandom_range(0, 7)));
    end else if (roll < noise_pct + (100 - noise_pct) * 55 / 100) begin
      send_word(CMD_REQUEST, pick_queue(1'b0), pick_length(),
                MARK_W'($urandom_range(0, 7)), MARK_W'($urandom_range(0, 7)));
    end else begin
      send_word(CMD_RELEASE, pick_queue(1'b1), LEN_W'($urandom_range(0, 255)),
                MARK_W'($urandom_range(0, 7)), MARK_W'($urandom_range(0, 7)));
    end
  endtask

  task automatic test_status_codes();
    send_word(CMD_RELEASE, 6'd0, LEN_16, 3'd0, 3'd0);
    send_word(CMD_RELEASE, 6'd63, 8'd255, 3'd7, 3'd7);
    send_word(CMD_REQUEST, 6'd0, 8'd0, 3'd0, 3'd0);
    send_word(CMD_REQUEST, 6'd0, 8'd255, 3'd7, 3'd7);
    send_word(CMD_REQUEST, 6'd0, 8'd17, 3'd1, 3'd2);
    send_word(CMD_REQUEST, 6'd0, LEN_16, 3'd7, 3'd7);
    send_word(CMD_REQUEST, 6'd0, LEN_32, 3'd0, 3'd0);
    send_word(CMD_REQUEST, 6'd63, LEN_128, 3'd0, 3'd0);
    send_word(CMD_RELEASE, 6'd0, 8'd0, 3'd0, 3'd0);
    send_word(CMD_RELEASE, 6'd0, 8'd0, 3'd0, 3'd0);
    send_word(CMD_RELEASE, 6'd63, 8'd0, 3'd0, 3'd0);
    wait_status_drained();
  endtask

  // 8-unit buffers until the store runs out, then the last half window
  task automatic test_store_full();
    for (int q = 10; q < 26; q++) send_word(CMD_REQUEST, QID_W'(q), LEN_128, 3'd3, 3'd4);
    send_word(CMD_REQUEST, 6'd26, LEN_64, 3'd7, 3'd0);
    send_word(CMD_REQUEST, 6'd27, LEN_16, 3'd0, 3'd7);
    wait_status_drained();
  endtask

  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    for (int n = 0; n < count; n++) send_random_word(5);
    wait_status_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(int count);
    for (int n = 0; n < count; n++) begin
      send_random_word(10);
      if ($urandom_range(0, 99) == 0) wait_status_drained();
    end
    wait_status_drained();
  endtask

  task automatic test_malformed_commands(int count);
    for (int n = 0; n < count; n++) send_random_word(50);
    wait_status_drained();
  endtask

  // status checker
  always @(posedge clk_i) begin
    status_e want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_expect_q.size() == 0) begin
        $error("status word with no command waiting: %0d", status_o);
        fail_count++;
      end else begin
        want = status_expect_q.pop_front();
        if (status_o !== want) begin
          $error("status mismatch: expected %0d, actual %0d", want, status_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("queue_sram_block_allocator_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = 1'b0;
    queue_id_i     = '0;
    length_words_i = '0;
    empty_mark_i   = '0;
    full_mark_i    = '0;
    idle_on        = 1'b1;
    fail_count     = 0;
    idle_cycles    = 0;
    unit_busy_map  = '0;
    for (int u = 0; u < RESERVED_UNITS; u++) unit_busy_map[u] = 1'b1;
    for (int q = 0; q < QUEUES; q++) queue_word_model[q] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_status_codes();
    test_store_full();
    test_back_to_back(200);
    test_random_traffic(450);
    test_malformed_commands(350);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("queue_sram_block_allocator_unit_test: PASS");
    end else begin
      $display("queue_sram_block_allocator_unit_test: FAIL");
    end
    $finish;
  end

endmodule
